// ===== src/pep_pkg.sv =====
// ----------------------------------------------------------------------------
// pep_pkg
// Types and constants shared by the page escape update parser.
// ----------------------------------------------------------------------------
package pep_pkg;

  localparam logic [7:0]  ESC_BYTE     = 8'h1B;
  localparam logic [7:0]  DIGIT_ZERO   = 8'd48;
  localparam logic [7:0]  RADIX        = 8'd10;
  localparam logic [7:0]  TERM_MOVE    = 8'h60;
  localparam logic [7:0]  TERM_REPEAT  = 8'h62;
  localparam logic [11:0] COUNT_MAX    = 12'd4095;
  localparam logic [12:0] CURSOR_LIMIT = 13'd4096;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_of_update;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [11:0] write_position;
    logic [7:0]  write_char;
    logic [12:0] run_length;
    logic        clipped;
    logic        end_of_update;
  } out_item_t;

  typedef struct packed {
    logic [11:0] position;
    logic [7:0]  char_code;
    logic [12:0] run_length;
    logic        clipped;
    logic [12:0] next_cursor;
  } run_t;

endpackage

// ===== src/pep_stream_if.sv =====
// ----------------------------------------------------------------------------
// pep_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface pep_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pep_run_unit.sv =====
// ----------------------------------------------------------------------------
// pep_run_unit
// Clips a write run at the cursor against the page length and advances
// the cursor with saturation.
// ----------------------------------------------------------------------------
module pep_run_unit (
  input  logic [12:0]   cursor,
  input  logic [11:0]   req,
  input  logic [12:0]   len,
  input  logic [7:0]    char_code,
  output pep_pkg::run_t run
);

  logic [12:0] room;
  logic [12:0] req_ext;
  logic [12:0] done;
  logic [13:0] sum;

  always_comb begin
    req_ext = {1'b0, req};
    room    = (cursor < len) ? (len - cursor) : 13'd0;
    done    = (req_ext < room) ? req_ext : room;
    sum     = {1'b0, cursor} + {2'b00, req};

    run.position    = cursor[11:0];
    run.char_code   = char_code;
    run.run_length  = done;
    run.clipped     = (done < req_ext);
    run.next_cursor = (sum > {1'b0, pep_pkg::CURSOR_LIMIT}) ? pep_pkg::CURSOR_LIMIT
                                                             : sum[12:0];
  end

endmodule

// ===== src/page_escape_update_parser.sv =====
// ----------------------------------------------------------------------------
// page_escape_update_parser
// Parses a page-update byte stream into clipped write runs on a text page.
// ----------------------------------------------------------------------------
// Each accepted item's result is captured in the output register.
// Throughput: 1 item per cycle while the output is not stalled; parser state and
// run clipping settle in one pass of logic ahead of the output register.
// A stalled result holds the output register and blocks the input.
// Reset: synchronous, clears parser state, cursor, last character and
// output valid, and sets page_length to 4096.
// ----------------------------------------------------------------------------
module page_escape_update_parser #(
  parameter int PAGE_SIZE = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  pep_stream_if.sink         in_s,
  pep_stream_if.source       out_s,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data
);

  localparam int LEN_LIMIT = (PAGE_SIZE < 4096) ? PAGE_SIZE : 4096;

  pep_pkg::mode_t     mode_r, mode_nxt;
  logic [11:0]        count_r, count_nxt;
  logic [12:0]        cursor_r, cursor_nxt;
  logic [7:0]         last_char_r, last_char_nxt;
  logic [12:0]        page_length_r;
  logic               out_valid_r;
  pep_pkg::out_item_t out_item_r, out_item_nxt;

  logic               accept;
  logic               wrote;
  logic [7:0]         b;
  logic               last;
  logic               is_digit;
  logic [15:0]        digit_val;
  logic [12:0]        len;
  logic [11:0]        req;
  logic [7:0]         run_char;
  pep_pkg::run_t      run;

  assign in_s.ready    = !out_valid_r || out_s.ready;
  assign accept        = in_s.valid && in_s.ready;
  assign out_s.valid   = out_valid_r;
  assign out_s.payload = out_item_r;

  assign b        = in_s.payload.stream_byte;
  assign last     = in_s.payload.last_of_update;
  assign len      = (page_length_r > 13'(LEN_LIMIT)) ? 13'(LEN_LIMIT) : page_length_r;
  assign is_digit = (b >= pep_pkg::DIGIT_ZERO) &&
                    (b < (pep_pkg::DIGIT_ZERO + pep_pkg::RADIX));
  assign digit_val = {1'b0, count_r, 3'b000} + {3'b000, count_r, 1'b0}
                   + 16'(b - pep_pkg::DIGIT_ZERO);
  assign req      = (mode_r == pep_pkg::MODE_DIGITS) ? (count_r - 12'd1) : 12'd1;
  assign run_char = (mode_r == pep_pkg::MODE_DIGITS) ? last_char_r : b;

  pep_run_unit u_run (
    .cursor    (cursor_r),
    .req       (req),
    .len       (len),
    .char_code (run_char),
    .run       (run)
  );

  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    last_char_nxt = last_char_r;
    wrote         = 1'b0;

    case (mode_r)
      pep_pkg::MODE_SKIP: begin
        mode_nxt  = pep_pkg::MODE_DIGITS;
        count_nxt = 12'd0;
      end
      pep_pkg::MODE_DIGITS: begin
        if (is_digit) begin
          count_nxt = (digit_val > {4'b0000, pep_pkg::COUNT_MAX}) ? pep_pkg::COUNT_MAX
                                                                  : digit_val[11:0];
        end else begin
          if (b == pep_pkg::TERM_MOVE) begin
            cursor_nxt = {1'b0, count_r};
          end else if (b == pep_pkg::TERM_REPEAT && count_r > 12'd1) begin
            wrote      = 1'b1;
            cursor_nxt = run.next_cursor;
          end
          mode_nxt  = pep_pkg::MODE_NORMAL;
          count_nxt = 12'd0;
        end
      end
      default: begin
        mode_nxt = pep_pkg::MODE_NORMAL;
        if (b == pep_pkg::ESC_BYTE) begin
          mode_nxt = pep_pkg::MODE_SKIP;
        end else begin
          last_char_nxt = b;
          wrote         = 1'b1;
          cursor_nxt    = run.next_cursor;
        end
      end
    endcase

    if (last) begin
      mode_nxt      = pep_pkg::MODE_NORMAL;
      count_nxt     = 12'd0;
      cursor_nxt    = 13'd0;
      last_char_nxt = 8'd0;
    end

    out_item_nxt                = '0;
    out_item_nxt.end_of_update  = last;
    if (wrote) begin
      out_item_nxt.write_valid    = 1'b1;
      out_item_nxt.write_position = run.position;
      out_item_nxt.write_char     = run.char_code;
      out_item_nxt.run_length     = run.run_length;
      out_item_nxt.clipped        = run.clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= pep_pkg::MODE_NORMAL;
      count_r       <= 12'd0;
      cursor_r      <= 13'd0;
      last_char_r   <= 8'd0;
      page_length_r <= 13'd4096;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        page_length_r <= cfg_wr_data;
      end
      if (accept) begin
        mode_r      <= mode_nxt;
        count_r     <= count_nxt;
        cursor_r    <= cursor_nxt;
        last_char_r <= last_char_nxt;
        out_valid_r <= wrote || last;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ===== src/pep_checker.sv =====
// ----------------------------------------------------------------------------
// pep_checker
// Port-level checks on the page escape update parser.
// ----------------------------------------------------------------------------
module pep_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pep_pkg::out_item_t out_payload
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
    else $error("stalled item changed");

  a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload.write_valid) |->
      (out_payload.end_of_update && out_payload.write_position == 12'd0 &&
       out_payload.write_char == 8'd0 && out_payload.run_length == 13'd0 &&
       !out_payload.clipped))
    else $error("item without write carries run fields");

  a_unclipped_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload.write_valid && !out_payload.clipped) |->
      (out_payload.run_length != 13'd0))
    else $error("unclipped run is empty");

endmodule

bind page_escape_update_parser pep_checker u_pep_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_s.ready),
  .out_valid   (out_s.valid),
  .out_ready   (out_s.ready),
  .out_payload (out_s.payload)
);

// ===== dv/page_escape_update_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_escape_update_parser_tb
// Drives page-update byte streams into the parser under random valid/ready
// pressure and checks each write run against a cycle-free parser predictor,
// across several page lengths including zero, one and beyond the page size.
// ----------------------------------------------------------------------------
module page_escape_update_parser_tb;

  localparam int PAGE_CELLS  = 4096;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 210;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [12:0] cfg_wr_data;

  pep_stream_if #(.payload_t(pep_pkg::in_item_t))  in_ch ();
  pep_stream_if #(.payload_t(pep_pkg::out_item_t)) out_ch ();

  page_escape_update_parser #(.PAGE_SIZE(PAGE_CELLS)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (in_ch),
    .out_s       (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pep_pkg::in_item_t  pending_bytes[$];
  pep_pkg::out_item_t expected_runs[$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 bad_results;
  int                 quiet_cycles;

  logic [12:0]        page_len_cfg;
  logic [12:0]        cursor_pos;
  logic [11:0]        count_acc;
  logic [7:0]         last_chr;
  pep_pkg::mode_t     parse_st;

  always #4 clk = ~clk;

  function automatic logic [12:0] eff_page_len();
    return (page_len_cfg > pep_pkg::CURSOR_LIMIT) ? pep_pkg::CURSOR_LIMIT : page_len_cfg;
  endfunction

  function automatic void apply_run(input logic [12:0] req, inout pep_pkg::out_item_t res);
    logic [12:0] eff;
    logic [12:0] room;
    logic [12:0] done;
    logic [13:0] nxt;
    eff  = eff_page_len();
    room = (cursor_pos < eff) ? eff - cursor_pos : 13'd0;
    done = (req < room) ? req : room;
    res.write_valid    = 1'b1;
    res.write_position = cursor_pos[11:0];
    res.write_char     = last_chr;
    res.run_length     = done;
    res.clipped        = (done < req);
    nxt = {1'b0, cursor_pos} + {1'b0, req};
    cursor_pos = (nxt > {1'b0, pep_pkg::CURSOR_LIMIT}) ? pep_pkg::CURSOR_LIMIT : nxt[12:0];
  endfunction

  function automatic bit predict_parse(input pep_pkg::in_item_t it,
                                       output pep_pkg::out_item_t res);
    bit wrote;
    int v;
    res   = '0;
    wrote = 1'b0;
    case (parse_st)
      pep_pkg::MODE_SKIP: begin
        parse_st  = pep_pkg::MODE_DIGITS;
        count_acc = '0;
      end
      pep_pkg::MODE_DIGITS: begin
        if (it.stream_byte >= pep_pkg::DIGIT_ZERO &&
            it.stream_byte < pep_pkg::DIGIT_ZERO + pep_pkg::RADIX) begin
          v = int'(count_acc) * int'(pep_pkg::RADIX)
            + int'(it.stream_byte - pep_pkg::DIGIT_ZERO);
          count_acc = (v > int'(pep_pkg::COUNT_MAX)) ? pep_pkg::COUNT_MAX : 12'(v);
        end else begin
          if (it.stream_byte == pep_pkg::TERM_MOVE) begin
            cursor_pos = {1'b0, count_acc};
          end else if (it.stream_byte == pep_pkg::TERM_REPEAT && count_acc > 12'd1) begin
            apply_run({1'b0, count_acc} - 13'd1, res);
            wrote = 1'b1;
          end
          parse_st  = pep_pkg::MODE_NORMAL;
          count_acc = '0;
        end
      end
      default: begin
        parse_st = pep_pkg::MODE_NORMAL;
        if (it.stream_byte == pep_pkg::ESC_BYTE) begin
          parse_st = pep_pkg::MODE_SKIP;
        end else begin
          last_chr = it.stream_byte;
          apply_run(13'd1, res);
          wrote = 1'b1;
        end
      end
    endcase
    if (it.last_of_update) begin
      res.end_of_update = 1'b1;
      parse_st   = pep_pkg::MODE_NORMAL;
      count_acc  = '0;
      cursor_pos = '0;
      last_chr   = '0;
      return 1'b1;
    end
    return wrote;
  endfunction

  always @(posedge clk) begin : driver
    pep_pkg::out_item_t res;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (predict_parse(in_ch.payload, res)) expected_runs.push_back(res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.payload <= pending_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pep_pkg::out_item_t want;
    pep_pkg::out_item_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_runs.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result: wv=%0d pos=%0d ch=%02h len=%0d clip=%0d eou=%0d",
                     got.write_valid, got.write_position, got.write_char,
                     got.run_length, got.clipped, got.end_of_update);
        end else begin
          want = expected_runs.pop_front();
          if (got.write_valid !== want.write_valid ||
              got.write_position !== want.write_position ||
              got.write_char !== want.write_char ||
              got.run_length !== want.run_length ||
              got.clipped !== want.clipped ||
              got.end_of_update !== want.end_of_update) begin
            bad_results++;
            if (bad_results <= 10)
              $display({"mismatch: exp wv=%0d pos=%0d ch=%02h len=%0d clip=%0d eou=%0d",
                        " | got wv=%0d pos=%0d ch=%02h len=%0d clip=%0d eou=%0d"},
                       want.write_valid, want.write_position, want.write_char,
                       want.run_length, want.clipped, want.end_of_update,
                       got.write_valid, got.write_position, got.write_char,
                       got.run_length, got.clipped, got.end_of_update);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last = 1'b0);
    pep_pkg::in_item_t it;
    it.stream_byte    = b;
    it.last_of_update = last;
    pending_bytes.push_back(it);
  endtask

  task automatic close_update();
    pep_pkg::in_item_t it;
    it = pending_bytes.pop_back();
    it.last_of_update = 1'b1;
    pending_bytes.push_back(it);
  endtask

  task automatic push_escape(input logic [7:0] skip_b, input int count, input logic [7:0] term);
    logic [7:0] digs[$];
    int n;
    n = count;
    push_byte(pep_pkg::ESC_BYTE);
    push_byte(skip_b);
    if (count >= 0) begin
      do begin
        digs.push_front(pep_pkg::DIGIT_ZERO + 8'(n % 10));
        n = n / 10;
      end while (n > 0);
      foreach (digs[i]) push_byte(digs[i]);
    end
    push_byte(term);
  endtask

  task automatic push_random_update();
    int parts;
    int sel;
    int lim;
    logic [7:0] b;
    parts = $urandom_range(1, 6);
    repeat (parts) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        repeat ($urandom_range(1, 8)) begin
          b = 8'($urandom_range(255));
          push_byte((b == pep_pkg::ESC_BYTE) ? 8'h20 : b);
        end
      end else if (sel < 70) begin
        lim = (eff_page_len() < pep_pkg::CURSOR_LIMIT) ? int'(eff_page_len()) + 4
                                                       : int'(pep_pkg::COUNT_MAX);
        push_escape(8'($urandom_range(255)),
                    ($urandom_range(1) != 0) ? $urandom_range(lim)
                                             : $urandom_range(pep_pkg::COUNT_MAX),
                    pep_pkg::TERM_MOVE);
      end else if (sel < 88) begin
        case ($urandom_range(9))
          0:       push_escape(8'($urandom_range(255)), $urandom_range(pep_pkg::COUNT_MAX),
                               pep_pkg::TERM_REPEAT);
          1:       push_escape(8'($urandom_range(255)), $urandom_range(4000, 99999),
                               pep_pkg::TERM_REPEAT);
          2:       push_escape(8'($urandom_range(255)), -1, pep_pkg::TERM_REPEAT);
          default: push_escape(8'($urandom_range(255)), $urandom_range(12),
                               pep_pkg::TERM_REPEAT);
        endcase
      end else if (sel < 96) begin
        push_escape(8'($urandom_range(255)),
                    ($urandom_range(3) == 0) ? -1 : $urandom_range(999999),
                    8'($urandom_range(255)));
      end else begin
        push_byte(pep_pkg::ESC_BYTE);
        if ($urandom_range(1) != 0) push_byte(8'($urandom_range(255)));
        repeat ($urandom_range(2)) push_byte(pep_pkg::DIGIT_ZERO + 8'($urandom_range(9)));
      end
    end
    close_update();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_runs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_page_length(input logic [12:0] len);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    page_len_cfg = len;
  endtask

  initial begin
    logic [12:0] page_cfgs[6];
    int          filled;
    page_cfgs     = '{13'd40, 13'd1, 13'd0, 13'd960, 13'd8191, 13'd4096};
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    bad_results   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 22;
    recv_idle_pct = 55;
    page_len_cfg  = 13'd4096;
    cursor_pos    = '0;
    count_acc     = '0;
    last_chr      = '0;
    parse_st      = pep_pkg::MODE_NORMAL;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(8'h41);
    push_escape(8'hFF, 5, pep_pkg::TERM_REPEAT);
    push_escape(8'h00, 1, pep_pkg::TERM_REPEAT);
    push_escape(8'h39, -1, pep_pkg::TERM_REPEAT);
    push_escape(8'h78, 7, 8'h7A);
    push_escape(pep_pkg::ESC_BYTE, 99999, pep_pkg::TERM_MOVE);
    push_byte(8'hFF);
    push_byte(8'h00, 1'b1);
    push_byte(pep_pkg::ESC_BYTE, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 55;
        recv_idle_pct = 22;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_page_length(page_cfgs[p]);
      filled = pending_bytes.size();
      while (pending_bytes.size() - filled < PHASE_ITEMS) begin
        if ($urandom_range(99) < 8)
          push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        else
          push_random_update();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (bad_results == 0 && expected_runs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pep_pkg.sv
src/pep_stream_if.sv
src/pep_run_unit.sv
src/page_escape_update_parser.sv
src/pep_checker.sv
dv/page_escape_update_parser_tb.sv
